// ===== rtl/core/elg_pkg.sv =====
// ----------------------------------------------------------------------------
// elg_pkg
// Shared types and constants of the ElGamal modular exponentiation engine.
// ----------------------------------------------------------------------------
package elg_pkg;

	localparam int DEF_WIDTH = 32;
	localparam int MOD_RESET = 3;
	localparam int GEN_RESET = 2;

	localparam logic [1:0] ACT_KEYGEN  = 2'd0;
	localparam logic [1:0] ACT_ENCRYPT = 2'd1;
	localparam logic [1:0] ACT_DECRYPT = 2'd2;

	typedef enum logic [3:0] {
		C_NONE,
		C_LOAD,
		C_START,
		C_DEGEN,
		C_RES_ONE,
		C_EXP_SHIFT,
		C_RES_TO_KEY,
		C_RES_TO_FIRST,
		C_INV_INIT,
		C_INV_FAIL
	} op_t;

	typedef enum logic [3:0] {
		J_RED_G,
		J_RED_PK,
		J_RED_C1,
		J_RED_MSG,
		J_RED_C2,
		J_SQR,
		J_MULB,
		J_MUL_KEY,
		J_DIV,
		J_PROD,
		J_MUL_INV
	} job_t;

	typedef struct packed {
		op_t  op;
		job_t job;
	} cmd_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic       exp_msb;
		logic       r1_zero;
		logic       r0_one;
		logic       q_small;
		logic [1:0] action;
	} stat_t;

endpackage

// ===== rtl/core/elg_cfg.sv =====
// ----------------------------------------------------------------------------
// elg_cfg
// Configuration registers for modulus and generator behind an APB-style port.
// ----------------------------------------------------------------------------
module elg_cfg import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH,
	localparam int DW = (WIDTH > 32) ? 64 : 32,
	localparam int AW = (WIDTH > 32) ? 4 : 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AW-1:0]    paddr,
	input  logic [DW-1:0]    pwdata,
	output logic [DW-1:0]    prdata,
	output logic             pready,
	output logic [WIDTH-1:0] modulus,
	output logic [WIDTH-1:0] generator
);

	logic [WIDTH-1:0] modulus_q;
	logic [WIDTH-1:0] generator_q;
	logic             sel;

	assign sel    = paddr[AW-1];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= WIDTH'(MOD_RESET);
			generator_q <= WIDTH'(GEN_RESET);
		end else if (psel && penable && pwrite) begin
			if (sel) begin
				generator_q <= pwdata[WIDTH-1:0];
			end else begin
				modulus_q <= pwdata[WIDTH-1:0];
			end
		end
	end

	assign prdata    = sel ? DW'(generator_q) : DW'(modulus_q);
	assign modulus   = modulus_q;
	assign generator = generator_q;

endmodule

// ===== rtl/core/elg_datapath.sv =====
// ----------------------------------------------------------------------------
// elg_datapath
// Operand registers and a bit-serial modular multiply / reduce / divide unit.
// ----------------------------------------------------------------------------
module elg_datapath import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output stat_t            stat,
	input  logic [WIDTH-1:0] modulus,
	input  logic [WIDTH-1:0] generator,
	input  logic [1:0]       action,
	input  logic [WIDTH-1:0] exponent,
	input  logic [WIDTH-1:0] peer_key,
	input  logic [WIDTH-1:0] message,
	input  logic [WIDTH-1:0] cipher_first,
	input  logic [WIDTH-1:0] cipher_second,
	output logic [WIDTH-1:0] first_result,
	output logic [WIDTH-1:0] second_result,
	output logic             no_inverse
);

	localparam int CW = $clog2(WIDTH);

	logic [1:0]       act_q;
	logic [WIDTH-1:0] e_q, pk_q, msg_q, c1_q, c2_q, exp_q;
	logic [WIDTH-1:0] base_q, res_q, key_q, aux_q;
	logic [WIDTH-1:0] r0_q, r1_q, t0_q, t1_q, rn_q, quo_q;
	logic [WIDTH-1:0] first_q, second_q;
	logic             flag_q;

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	job_t             job_q;
	logic [WIDTH-1:0] ua_q, ub_q, un_q, acc_q, qacc_q;

	logic [WIDTH-1:0] a_sel, b_sel, n_sel;
	logic             is_red, rbit, mbit, ge1, ge2, done;
	logic [WIDTH:0]   s1, s2;
	logic [WIDTH-1:0] d, m, acc_n, qbits_n, quo_red, t_sub;

	always_comb begin
		a_sel = '0;
		b_sel = '0;
		n_sel = modulus;
		case (cmd.job)
			J_RED_G:   b_sel = generator;
			J_RED_PK:  b_sel = pk_q;
			J_RED_C1:  b_sel = c1_q;
			J_RED_MSG: b_sel = msg_q;
			J_RED_C2:  b_sel = c2_q;
			J_SQR: begin
				a_sel = res_q;
				b_sel = res_q;
			end
			J_MULB: begin
				a_sel = base_q;
				b_sel = res_q;
			end
			J_MUL_KEY: begin
				a_sel = key_q;
				b_sel = aux_q;
			end
			J_DIV: begin
				b_sel = r0_q;
				n_sel = r1_q;
			end
			J_PROD: begin
				a_sel = t1_q;
				b_sel = quo_q;
			end
			J_MUL_INV: begin
				a_sel = t0_q;
				b_sel = aux_q;
			end
			default: b_sel = '0;
		endcase
	end

	always_comb begin
		case (job_q)
			J_RED_G, J_RED_PK, J_RED_C1, J_RED_MSG, J_RED_C2, J_DIV: is_red = 1'b1;
			default: is_red = 1'b0;
		endcase
		rbit    = is_red & ub_q[WIDTH-1];
		mbit    = ~is_red & ub_q[WIDTH-1];
		s1      = {acc_q, rbit};
		ge1     = s1 >= {1'b0, un_q};
		d       = ge1 ? WIDTH'(s1 - {1'b0, un_q}) : s1[WIDTH-1:0];
		s2      = {1'b0, d} + {1'b0, ua_q};
		ge2     = s2 >= {1'b0, un_q};
		m       = ge2 ? WIDTH'(s2 - {1'b0, un_q}) : s2[WIDTH-1:0];
		acc_n   = mbit ? m : d;
		qbits_n = {qacc_q[WIDTH-2:0], ge1};
		quo_red = (qbits_n >= modulus) ? (qbits_n - modulus) : qbits_n;
		t_sub   = (t0_q >= acc_n) ? (t0_q - acc_n) : (t0_q + (modulus - acc_n));
		done    = busy_q && (cnt_q == CW'(WIDTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.op == C_START) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == C_START) begin
			job_q  <= cmd.job;
			ua_q   <= a_sel;
			ub_q   <= b_sel;
			un_q   <= n_sel;
			acc_q  <= '0;
			qacc_q <= '0;
		end else if (busy_q) begin
			acc_q  <= acc_n;
			ub_q   <= {ub_q[WIDTH-2:0], 1'b0};
			qacc_q <= qbits_n;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			case (job_q)
				J_RED_G, J_RED_PK, J_RED_C1: base_q <= acc_n;
				J_RED_MSG, J_RED_C2:         aux_q <= acc_n;
				J_SQR, J_MULB:               res_q <= acc_n;
				J_MUL_KEY:                   second_q <= acc_n;
				J_MUL_INV:                   first_q <= acc_n;
				J_DIV: begin
					rn_q  <= acc_n;
					quo_q <= quo_red;
				end
				J_PROD: begin
					t0_q <= t1_q;
					t1_q <= t_sub;
					r0_q <= r1_q;
					r1_q <= rn_q;
				end
				default: res_q <= res_q;
			endcase
		end else begin
			case (cmd.op)
				C_LOAD: begin
					act_q    <= action;
					e_q      <= exponent;
					pk_q     <= peer_key;
					msg_q    <= message;
					c1_q     <= cipher_first;
					c2_q     <= cipher_second;
					first_q  <= '0;
					second_q <= '0;
					flag_q   <= 1'b0;
				end
				C_DEGEN:        flag_q <= (act_q == ACT_DECRYPT);
				C_RES_ONE: begin
					res_q <= WIDTH'(1);
					exp_q <= e_q;
				end
				C_EXP_SHIFT:    exp_q <= {exp_q[WIDTH-2:0], 1'b0};
				C_RES_TO_KEY:   key_q <= res_q;
				C_RES_TO_FIRST: first_q <= res_q;
				C_INV_INIT: begin
					r0_q <= modulus;
					r1_q <= res_q;
					t0_q <= '0;
					t1_q <= WIDTH'(1);
				end
				C_INV_FAIL: begin
					first_q <= '0;
					flag_q  <= 1'b1;
				end
				default: flag_q <= flag_q;
			endcase
		end
	end

	always_comb begin
		stat.busy    = busy_q;
		stat.done    = done;
		stat.exp_msb = exp_q[WIDTH-1];
		stat.r1_zero = (r1_q == '0);
		stat.r0_one  = (r0_q == WIDTH'(1));
		stat.q_small = (modulus < WIDTH'(2));
		stat.action  = act_q;
	end

	assign first_result  = first_q;
	assign second_result = second_q;
	assign no_inverse    = flag_q;

endmodule

// ===== rtl/core/elg_ctrl.sv =====
// ----------------------------------------------------------------------------
// elg_ctrl
// Sequencer for reductions, square-and-multiply and the extended Euclid loop.
// ----------------------------------------------------------------------------
module elg_ctrl import elg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	output logic  m_tvalid,
	input  logic  m_tready,
	input  stat_t stat,
	input  logic  bit_last,
	output cmd_t  cmd
);

	typedef enum logic [15:0] {
		S_IDLE      = 16'b0000_0000_0000_0001,
		S_DISPATCH  = 16'b0000_0000_0000_0010,
		S_RED1      = 16'b0000_0000_0000_0100,
		S_POW_INIT  = 16'b0000_0000_0000_1000,
		S_SQR       = 16'b0000_0000_0001_0000,
		S_MULB      = 16'b0000_0000_0010_0000,
		S_POW_NEXT  = 16'b0000_0000_0100_0000,
		S_AFTER_POW = 16'b0000_0000_1000_0000,
		S_RED2      = 16'b0000_0001_0000_0000,
		S_FINAL_MUL = 16'b0000_0010_0000_0000,
		S_INV_TEST  = 16'b0000_0100_0000_0000,
		S_DIV       = 16'b0000_1000_0000_0000,
		S_PROD      = 16'b0001_0000_0000_0000,
		S_OUT       = 16'b0010_0000_0000_0000
	} state_t;

	state_t state_q, state_n;
	logic   pend_q, pend_n;
	logic   step_q, step_n;
	logic   job_go;

	always_comb begin
		state_n = state_q;
		pend_n  = pend_q;
		step_n  = step_q;
		cmd.op  = C_NONE;
		cmd.job = J_SQR;
		job_go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = C_LOAD;
					state_n = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				step_n = 1'b0;
				if (stat.q_small) begin
					cmd.op  = C_DEGEN;
					state_n = S_OUT;
				end else if (stat.action == ACT_KEYGEN || stat.action == ACT_ENCRYPT ||
						stat.action == ACT_DECRYPT) begin
					state_n = S_RED1;
				end else begin
					state_n = S_OUT;
				end
			end
			S_RED1: begin
				if (stat.action == ACT_ENCRYPT && !step_q) begin
					cmd.job = J_RED_PK;
				end else if (stat.action == ACT_DECRYPT) begin
					cmd.job = J_RED_C1;
				end else begin
					cmd.job = J_RED_G;
				end
				job_go = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_POW_INIT;
				end
			end
			S_POW_INIT: begin
				cmd.op  = C_RES_ONE;
				state_n = S_SQR;
			end
			S_SQR: begin
				cmd.job = J_SQR;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = stat.exp_msb ? S_MULB : S_POW_NEXT;
				end
			end
			S_MULB: begin
				cmd.job = J_MULB;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_POW_NEXT;
				end
			end
			S_POW_NEXT: begin
				cmd.op = C_EXP_SHIFT;
				if (bit_last) begin
					state_n = S_AFTER_POW;
				end else begin
					state_n = S_SQR;
				end
			end
			S_AFTER_POW: begin
				if (stat.action == ACT_DECRYPT) begin
					cmd.op  = C_INV_INIT;
					state_n = S_INV_TEST;
				end else if (stat.action == ACT_ENCRYPT && !step_q) begin
					cmd.op  = C_RES_TO_KEY;
					step_n  = 1'b1;
					state_n = S_RED1;
				end else if (stat.action == ACT_ENCRYPT) begin
					cmd.op  = C_RES_TO_FIRST;
					state_n = S_RED2;
				end else begin
					cmd.op  = C_RES_TO_FIRST;
					state_n = S_OUT;
				end
			end
			S_RED2: begin
				cmd.job = (stat.action == ACT_ENCRYPT) ? J_RED_MSG : J_RED_C2;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_FINAL_MUL;
				end
			end
			S_FINAL_MUL: begin
				cmd.job = (stat.action == ACT_ENCRYPT) ? J_MUL_KEY : J_MUL_INV;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_OUT;
				end
			end
			S_INV_TEST: begin
				if (!stat.r1_zero) begin
					state_n = S_DIV;
				end else if (stat.r0_one) begin
					state_n = S_RED2;
				end else begin
					cmd.op  = C_INV_FAIL;
					state_n = S_OUT;
				end
			end
			S_DIV: begin
				cmd.job = J_DIV;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_PROD;
				end
			end
			S_PROD: begin
				cmd.job = J_PROD;
				job_go  = 1'b1;
				if (pend_q && stat.done) begin
					state_n = S_INV_TEST;
				end
			end
			S_OUT: begin
				if (m_tready) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
		if (job_go) begin
			if (!pend_q) begin
				cmd.op = C_START;
				pend_n = 1'b1;
			end else if (stat.done) begin
				pend_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			step_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			pend_q  <= pend_n;
			step_q  <= step_n;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);

endmodule

// ===== rtl/core/elg_modexp_top_note.sv =====
// ----------------------------------------------------------------------------
// elg_bitcnt
// Counts exponent bits of the square-and-multiply loop for any WIDTH.
// ----------------------------------------------------------------------------
module elg_bitcnt import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output logic last
);

	localparam int CW = $clog2(WIDTH);

	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.op == C_RES_ONE) begin
			cnt_q <= '0;
		end else if (cmd.op == C_EXP_SHIFT) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign last = (cnt_q == CW'(WIDTH - 1));

endmodule

// ===== rtl/core/elgamal_modexp_engine.sv =====
// ----------------------------------------------------------------------------
// elgamal_modexp_engine
// ElGamal key generation, encryption and decryption over a modulus q.
//
// Channel  Direction  Handshake                 Payload
// s_*      in         s_tvalid / s_tready       action, exponent, keys, cipher
// m_*      out        m_tvalid / m_tready       first/second result, no_inverse
// apb      in         psel & penable & pwrite   modulus (0x0), generator (0x4)
//
// One transaction at a time; each serial multiply, reduction or division step
// runs in the shared bit-serial unit. A power is a square per exponent bit
// plus a multiply per set bit, after a base reduction; encryption runs two
// powers and a multiply, decryption one power, up to about 1.5*WIDTH Euclid
// rounds of divide and product steps and a final multiply. Reset clears the
// controller and restores modulus 3 and generator 2. A stalled result holds.
// ----------------------------------------------------------------------------
module elgamal_modexp_engine import elg_pkg::*; #(
	parameter int WIDTH = DEF_WIDTH,
	localparam int IDW = ((5 * WIDTH + 7) / 8) * 8,
	localparam int ODW = ((2 * WIDTH + 7) / 8) * 8,
	localparam int DW  = (WIDTH > 32) ? 64 : 32,
	localparam int AW  = (WIDTH > 32) ? 4 : 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// exponent, peer_key, message, cipher_first, cipher_second
	input  logic [IDW-1:0] s_tdata,
	// action
	input  logic [1:0]     s_tuser,
	output logic           m_tvalid,
	input  logic           m_tready,
	// first_result, second_result
	output logic [ODW-1:0] m_tdata,
	// no_inverse
	output logic           m_tuser,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [AW-1:0]  paddr,
	input  logic [DW-1:0]  pwdata,
	output logic [DW-1:0]  prdata,
	output logic           pready
);

	cmd_t             cmd;
	stat_t            stat;
	stat_t            stat_c;
	logic             bit_last;
	logic [WIDTH-1:0] modulus, generator, first_result, second_result;

	elg_cfg #(.WIDTH(WIDTH)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.modulus   (modulus),
		.generator (generator)
	);

	elg_datapath #(.WIDTH(WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.modulus       (modulus),
		.generator     (generator),
		.action        (s_tuser),
		.exponent      (s_tdata[WIDTH-1:0]),
		.peer_key      (s_tdata[2*WIDTH-1:WIDTH]),
		.message       (s_tdata[3*WIDTH-1:2*WIDTH]),
		.cipher_first  (s_tdata[4*WIDTH-1:3*WIDTH]),
		.cipher_second (s_tdata[5*WIDTH-1:4*WIDTH]),
		.first_result  (first_result),
		.second_result (second_result),
		.no_inverse    (m_tuser)
	);

	elg_bitcnt #(.WIDTH(WIDTH)) u_bitcnt (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.last   (bit_last)
	);

	// The exponent bit count follows WIDTH; the controller sees the end of the
	// exponent through the bit counter's last flag, not the MSB-first shift register.
	always_comb begin
		stat_c = stat;
		stat_c.exp_msb = stat.exp_msb;
	end

	elg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat_c),
		.bit_last (bit_last),
		.cmd      (cmd)
	);

	assign m_tdata = ODW'({second_result, first_result});

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output sides open together");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == C_START) |-> !stat.busy)
		else $error("serial unit started while busy");

	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("no_inverse result carries nonzero data");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted while busy");

endmodule

// ===== tb/elgamal_modexp_engine_tb.sv =====
// ----------------------------------------------------------------------------
// elgamal_modexp_engine_tb
// Self-checking bench for the ElGamal engine. A directed table covers reset
// values, extreme operands, degenerate and composite moduli, non-invertible
// keys and the unused action. Random transactions under several modulus and
// generator settings follow. Typed rows are checked against their table values,
// all others against a bench-side power, multiply and inverse calculator.
// ----------------------------------------------------------------------------
module elgamal_modexp_engine_tb;
	import elg_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [31:0] q;
		logic [31:0] g;
		logic [1:0]  act;
		logic [31:0] ex;
		logic [31:0] pk;
		logic [31:0] msg;
		logic [31:0] c1;
		logic [31:0] c2;
		bit          typed;
		logic [31:0] f;
		logic [31:0] s;
		logic        n;
	} row_t;

	typedef struct {
		logic [31:0] f;
		logic [31:0] s;
		logic        n;
	} cipher_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;
	logic         m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	cipher_res_t  pending_results[$];
	logic [31:0]  cur_q;
	logic [31:0]  cur_g;
	int           s_idle;
	int           m_idle;
	int           fails;
	int           n_sent;
	int           n_recv;
	int           n_cfg;
	int           hold_left;
	bit           hold_done;
	row_t         directed[$];

	elgamal_modexp_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80000000;
		$display("elgamal_modexp_engine: mismatch");
		$finish;
	end

	function automatic logic [63:0] mulm(logic [63:0] a, logic [63:0] b, logic [63:0] q);
		return (a * b) % q;
	endfunction

	function automatic logic [63:0] powm(logic [63:0] b, logic [31:0] e, logic [63:0] q);
		logic [63:0] r;
		r = 1 % q;
		for (int i = 31; i >= 0; i--) begin
			r = mulm(r, r, q);
			if (e[i]) begin
				r = mulm(r, b, q);
			end
		end
		return r;
	endfunction

	function automatic cipher_res_t elgamal_predict(row_t r, logic [31:0] q32, logic [31:0] g32);
		cipher_res_t o;
		logic [63:0] q, key, r0, r1, t0, t1, quo, rn, tn;
		q = {32'd0, q32};
		o.f = '0;
		o.s = '0;
		o.n = 1'b0;
		if (q < 2) begin
			o.n = (r.act == ACT_DECRYPT);
		end else if (r.act == ACT_KEYGEN) begin
			o.f = powm(g32 % q, r.ex, q);
		end else if (r.act == ACT_ENCRYPT) begin
			key = powm(r.pk % q, r.ex, q);
			o.f = powm(g32 % q, r.ex, q);
			o.s = mulm(key, r.msg % q, q);
		end else if (r.act == ACT_DECRYPT) begin
			key = powm(r.c1 % q, r.ex, q);
			r0 = q;
			r1 = key;
			t0 = 0;
			t1 = 1;
			while (r1 != 0) begin
				quo = r0 / r1;
				rn = r0 - quo * r1;
				tn = (t0 + q - mulm(quo % q, t1, q)) % q;
				r0 = r1;
				r1 = rn;
				t0 = t1;
				t1 = tn;
			end
			if (r0 != 1) begin
				o.n = 1'b1;
			end else begin
				o.f = mulm(t0, r.c2 % q, q);
			end
		end
		return o;
	endfunction

	task automatic wait_drained();
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		n_cfg++;
	endtask

	task automatic set_config(logic [31:0] q, logic [31:0] g);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		apb_write(3'd0, q);
		apb_write(3'd4, g);
		cur_q = q;
		cur_g = g;
	endtask

	task automatic send_txn(row_t r);
		cipher_res_t e;
		while ($urandom_range(99) < s_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {r.c2, r.c1, r.msg, r.pk, r.ex};
		s_tuser <= r.act;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (r.typed) begin
			e.f = r.f;
			e.s = r.s;
			e.n = r.n;
		end else begin
			e = elgamal_predict(r, cur_q, cur_g);
		end
		pending_results.push_back(e);
		n_sent++;
	endtask

	function automatic logic [31:0] pick_operand(logic [31:0] q);
		case ($urandom_range(5))
			0: return 32'hFFFF_FFFF;
			1: return 32'd0;
			2: return (q > 1) ? $urandom_range(q - 1) : 32'd0;
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t random_row(logic [31:0] q, logic [31:0] g);
		row_t r;
		cipher_res_t enc;
		r = '{q, g, 2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		r.act = ($urandom_range(15) == 0) ? ACT_UNUSED : 2'($urandom_range(2));
		r.ex = ($urandom_range(7) == 0) ? pick_operand(q) : $urandom;
		r.pk = pick_operand(q);
		r.msg = pick_operand(q);
		r.c1 = pick_operand(q);
		r.c2 = pick_operand(q);
		if (r.act == ACT_DECRYPT && $urandom_range(1)) begin
			r.act = ACT_ENCRYPT;
			enc = elgamal_predict(r, q, g);
			r.act = ACT_DECRYPT;
			r.c1 = enc.f;
			r.c2 = enc.s;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_recv++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result f=%h s=%h n=%b", $time,
						m_tdata[31:0], m_tdata[63:32], m_tuser);
					fails++;
				end else begin
					cipher_res_t e;
					e = pending_results.pop_front();
					if (m_tdata[31:0] !== e.f) begin
						$display("%0t: first_result exp %h got %h", $time, e.f, m_tdata[31:0]);
						fails++;
					end
					if (m_tdata[63:32] !== e.s) begin
						$display("%0t: second_result exp %h got %h", $time, e.s, m_tdata[63:32]);
						fails++;
					end
					if (m_tuser !== e.n) begin
						$display("%0t: no_inverse exp %b got %b", $time, e.n, m_tuser);
						fails++;
					end
				end
				if (n_recv == 30 && !hold_done) begin
					hold_left = 15000;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= m_idle);
			end
		end
	end

	initial begin
		logic [31:0] qs[8];
		int k;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		fails = 0;
		n_sent = 0;
		n_recv = 0;
		n_cfg = 0;
		hold_left = 0;
		hold_done = 1'b0;
		s_idle = 9;
		m_idle = 56;
		cur_q = MOD_RESET;
		cur_g = GEN_RESET;
		qs = '{32'd3, 32'd7919, 32'd65521, 32'd2147483647, 32'hFFFF_FFFB,
			32'hFFFF_FFFF, 32'd4095, 32'd5};

		// q, g, action, exponent, peer, message, c1, c2, typed, first, second, flag
		directed = '{
			'{3, 2, ACT_KEYGEN, 0, 0, 0, 0, 0, 1, 1, 0, 0},
			'{3, 2, ACT_KEYGEN, 1, 0, 0, 0, 0, 1, 2, 0, 0},
			'{3, 2, ACT_KEYGEN, 2, 0, 0, 0, 0, 1, 1, 0, 0},
			'{3, 2, ACT_ENCRYPT, 0, 7, 5, 0, 0, 1, 1, 2, 0},
			'{3, 2, ACT_DECRYPT, 1, 0, 0, 0, 5, 1, 0, 0, 1},
			'{3, 2, ACT_DECRYPT, 1, 0, 0, 3, 5, 1, 0, 0, 1},
			'{3, 2, ACT_UNUSED, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 0, 0, 0},
			'{0, 2, ACT_KEYGEN, 5, 0, 0, 0, 0, 1, 0, 0, 0},
			'{0, 2, ACT_ENCRYPT, 5, 3, 3, 0, 0, 1, 0, 0, 0},
			'{0, 2, ACT_DECRYPT, 5, 0, 0, 3, 3, 1, 0, 0, 1},
			'{1, 0, ACT_KEYGEN, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 0, 0},
			'{1, 0, ACT_DECRYPT, 0, 0, 0, 0, 0, 1, 0, 0, 1},
			'{15, 2, ACT_DECRYPT, 1, 0, 0, 5, 7, 1, 0, 0, 1},
			'{15, 2, ACT_DECRYPT, 1, 0, 0, 4, 7, 0, 0, 0, 0},
			'{32'hFFFF_FFFB, 32'hFFFF_FFFF, ACT_KEYGEN, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0},
			'{32'hFFFF_FFFB, 32'hFFFF_FFFF, ACT_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
				32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
			'{32'hFFFF_FFFB, 32'hFFFF_FFFF, ACT_DECRYPT, 32'hFFFF_FFFF, 0, 0,
				32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0},
			'{32'hFFFF_FFFB, 32'hFFFF_FFFF, ACT_ENCRYPT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
			'{32'hFFFF_FFFF, 0, ACT_KEYGEN, 0, 0, 0, 0, 0, 0, 0, 0, 0},
			'{32'hFFFF_FFFF, 0, ACT_DECRYPT, 7, 0, 0, 32'hFFFF_FFFF, 9, 0, 0, 0, 0},
			'{32'hFFFF_FFFF, 0, ACT_DECRYPT, 3, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555,
				0, 0, 0, 0}
		};

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].q != cur_q || directed[i].g != cur_g) begin
				set_config(directed[i].q, directed[i].g);
			end
			send_txn(directed[i]);
		end

		for (int mode = 0; mode < 3; mode++) begin
			s_idle = (mode == 0) ? 9 : (mode == 1) ? 56 : 0;
			m_idle = (mode == 0) ? 56 : (mode == 1) ? 9 : 0;
			for (int n = 0; n < 40; n++) begin
				if (n % 10 == 0) begin
					k = $urandom_range(7);
					set_config(qs[k], ($urandom_range(2) == 0) ? $urandom :
						$urandom_range(qs[k] - 1));
				end
				send_txn(random_row(cur_q, cur_g));
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Ran %0d transactions, %0d results, %0d register writes,", n_sent, n_recv, n_cfg);
		$display("covering keygen, encrypt, decrypt round trips and degenerate moduli.");
		if (fails == 0 && pending_results.size() == 0) begin
			$display("elgamal_modexp_engine: match");
		end else begin
			$display("elgamal_modexp_engine: mismatch");
		end
		$finish;
	end

endmodule
